// ===== rtl/atsl_pkg.sv =====
// ----------------------------------------------------------------------------
// atsl_pkg
// Shared sizes, types and helpers of the texture slot table with LRU
// replacement.
// ----------------------------------------------------------------------------
package atsl_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [2*KEY_W-1:0]   key_t;

  // access from the sequencer to the entry memory
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_addr;
    logic   wr_key_en;
    logic   wr_time_en;
    idx_t   wr_addr;
    key_t   wr_key;
    stamp_t wr_time;
  } mem_req_t;

  // registered read data of the entry memory
  typedef struct packed {
    key_t   key;
    stamp_t stamp;
  } mem_rsp_t;

  // one result word
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              miss;
    logic              replaced;
  } rsp_t;

  // keep the low TIME_BITS bits of the caller's time, zero-extend if narrower
  function automatic stamp_t to_stamp(logic [NOW_W-1:0] now);
    logic [63:0] wide;
    wide = 64'(now);
    return wide[TIME_BITS-1:0];
  endfunction

  // slot field carries the low SLOT_W bits of the entry index
  function automatic logic [SLOT_W-1:0] to_slot(idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/atsl_if.sv =====
// ----------------------------------------------------------------------------
// atsl_req_if / atsl_rsp_if
// Valid/ready channels for lookup requests and slot results.
// ----------------------------------------------------------------------------
interface atsl_req_if;
  import atsl_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;
  logic [NOW_W-1:0] now_time;

  modport source (output valid, output key_low, output key_high, output now_time,
                  input ready);
  modport sink   (input valid, input key_low, input key_high, input now_time,
                  output ready);
endinterface

interface atsl_rsp_if;
  import atsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              miss;
  logic              replaced;

  modport source (output valid, output slot, output miss, output replaced,
                  input ready);
  modport sink   (input valid, input slot, input miss, input replaced,
                  output ready);
endinterface

// ===== rtl/atsl_entry_mem.sv =====
// ----------------------------------------------------------------------------
// atsl_entry_mem
// Entry storage: key and last-use time per slot, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module atsl_entry_mem (
  input  logic               clk_i,
  input  atsl_pkg::mem_req_t mem_req_i,
  output atsl_pkg::mem_rsp_t mem_rsp_o
);
  import atsl_pkg::*;

  key_t     key_mem   [ENTRIES];
  stamp_t   stamp_mem [ENTRIES];
  mem_rsp_t rd_q;

  // write key and time, read both at one address
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_key_en) begin
      key_mem[mem_req_i.wr_addr] <= mem_req_i.wr_key;
    end
    if (mem_req_i.wr_time_en) begin
      stamp_mem[mem_req_i.wr_addr] <= mem_req_i.wr_time;
    end
    if (mem_req_i.rd_en) begin
      rd_q.key   <= key_mem[mem_req_i.rd_addr];
      rd_q.stamp <= stamp_mem[mem_req_i.rd_addr];
    end
  end

  assign mem_rsp_o = rd_q;

endmodule

// ===== rtl/atsl_out_reg.sv =====
// ----------------------------------------------------------------------------
// atsl_out_reg
// One-word result register that decouples the sequencer from the consumer.
// ----------------------------------------------------------------------------
module atsl_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  atsl_pkg::rsp_t data_i,
  output logic           free_o,
  atsl_rsp_if.source     rsp_o
);
  import atsl_pkg::*;

  logic valid_q, valid_d;
  rsp_t data_q;

  // take a new word when empty or while the held one drains
  assign free_o  = !valid_q || rsp_o.ready;
  assign valid_d = push_i || (valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign rsp_o.valid    = valid_q;
  assign rsp_o.slot     = data_q.slot;
  assign rsp_o.miss     = data_q.miss;
  assign rsp_o.replaced = data_q.replaced;

endmodule

// ===== rtl/atsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// atsl_ctrl
// Lookup sequencer: match scan over filled entries, age scan for the
// victim on a full miss, then write-back of time, and of the key on a miss.
// ----------------------------------------------------------------------------
module atsl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  atsl_req_if.sink           req_i,
  output atsl_pkg::mem_req_t mem_req_o,
  input  atsl_pkg::mem_rsp_t mem_rsp_i,
  input  logic               out_free_i,
  output logic               rsp_push_o,
  output atsl_pkg::rsp_t     rsp_data_o
);
  import atsl_pkg::*;

  localparam cnt_t ENTRY_CNT = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_LRU,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;
  cnt_t   fill_q, fill_d;
  logic   pend_q, pend_d;
  key_t   key_q, key_d;
  stamp_t now_q, now_d;
  cnt_t   limit_q, limit_d;
  cnt_t   issue_q, issue_d;
  idx_t   pend_idx_q, pend_idx_d;
  idx_t   idx_q, idx_d;
  logic   miss_q, miss_d;
  logic   repl_q, repl_d;
  stamp_t best_age_q, best_age_d;
  idx_t   best_idx_q, best_idx_d;

  logic   hit;
  stamp_t age;
  logic   take;

  assign hit  = (mem_rsp_i.key == key_q);
  assign age  = now_q - mem_rsp_i.stamp;
  assign take = pend_q && ((pend_idx_q == '0) || (age > best_age_q));

  // sequence the scans and the write-back
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    pend_d     = 1'b0;
    key_d      = key_q;
    now_d      = now_q;
    limit_d    = limit_q;
    issue_d    = issue_q;
    pend_idx_d = pend_idx_q;
    idx_d      = idx_q;
    miss_d     = miss_q;
    repl_d     = repl_q;
    best_age_d = best_age_q;
    best_idx_d = best_idx_q;
    mem_req_o  = '0;
    rsp_push_o = 1'b0;
    req_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d   = {req_i.key_high, req_i.key_low};
          now_d   = to_stamp(req_i.now_time);
          limit_d = fill_q;
          issue_d = '0;
          state_d = ST_MATCH;
        end
      end

      ST_MATCH: begin
        // issue next read, check the one that came back
        if (issue_q != limit_q) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = issue_q[IDX_W-1:0];
          issue_d           = issue_q + cnt_t'(1);
          pend_d            = 1'b1;
          pend_idx_d        = issue_q[IDX_W-1:0];
        end
        if (pend_q && hit) begin
          idx_d   = pend_idx_q;
          miss_d  = 1'b0;
          repl_d  = 1'b0;
          state_d = ST_WRITE;
        end else if (issue_q == limit_q) begin
          miss_d  = 1'b1;
          issue_d = '0;
          pend_d  = 1'b0;
          if (limit_q != ENTRY_CNT) begin
            idx_d   = limit_q[IDX_W-1:0];
            repl_d  = 1'b0;
            fill_d  = fill_q + cnt_t'(1);
            state_d = ST_WRITE;
          end else begin
            repl_d  = 1'b1;
            state_d = ST_LRU;
          end
        end
      end

      ST_LRU: begin
        // track the oldest entry, lowest index wins ties
        if (issue_q != ENTRY_CNT) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = issue_q[IDX_W-1:0];
          issue_d           = issue_q + cnt_t'(1);
          pend_d            = 1'b1;
          pend_idx_d        = issue_q[IDX_W-1:0];
        end
        if (take) begin
          best_age_d = age;
          best_idx_d = pend_idx_q;
        end
        if (issue_q == ENTRY_CNT) begin
          idx_d   = take ? pend_idx_q : best_idx_q;
          state_d = ST_WRITE;
        end
      end

      ST_WRITE: begin
        // commit entry and hand over the result word together
        if (out_free_i) begin
          mem_req_o.wr_key_en  = miss_q;
          mem_req_o.wr_time_en = 1'b1;
          mem_req_o.wr_addr    = idx_q;
          mem_req_o.wr_key     = key_q;
          mem_req_o.wr_time    = now_q;
          rsp_push_o           = 1'b1;
          state_d              = ST_IDLE;
        end
      end
    endcase
  end

  assign rsp_data_o = '{slot: to_slot(idx_q), miss: miss_q, replaced: repl_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    now_q      <= now_d;
    limit_q    <= limit_d;
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    idx_q      <= idx_d;
    miss_q     <= miss_d;
    repl_q     <= repl_d;
    best_age_q <= best_age_d;
    best_idx_q <= best_idx_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ENTRY_CNT)
    else $error("fill count beyond table size");

  a_repl_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_push_o && repl_q) |-> (fill_q == ENTRY_CNT))
    else $error("eviction while table not full");

  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH) |-> (issue_q <= limit_q))
    else $error("match scan past filled entries");

  a_write_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_time_en |-> (cnt_t'(idx_q) < fill_q))
    else $error("write to an entry outside the filled range");

  a_write_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && !out_free_i) |=> (state_q == ST_WRITE))
    else $error("write-back left while result register busy");

endmodule

// ===== rtl/assoc_texture_slot_lru.sv =====
// ----------------------------------------------------------------------------
// assoc_texture_slot_lru
// Fully associative slot table keyed by a 128-bit texture descriptor with
// least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request is handled at a time; all entry state sits in a synchronous
// memory with one read port that is scanned one entry per cycle. A hit
// ends the match scan at the matching entry, a fill miss scans every
// filled entry, and a miss on a full table adds a second scan over every
// entry to find the oldest one. The next request is taken as soon as the
// result has moved into the output register, even if the consumer has not
// yet taken it. No clearing pass is needed after reset: only entries below
// the fill count are read.
module assoc_texture_slot_lru (
  input  logic       clk_i,
  input  logic       rst_ni,
  atsl_req_if.sink   req_i,
  atsl_rsp_if.source rsp_o
);
  import atsl_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  logic     out_free;
  logic     rsp_push;
  rsp_t     rsp_data;

  atsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .mem_req_o  (mem_req),
    .mem_rsp_i  (mem_rsp),
    .out_free_i (out_free),
    .rsp_push_o (rsp_push),
    .rsp_data_o (rsp_data)
  );

  atsl_entry_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp)
  );

  atsl_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_push),
    .data_i (rsp_data),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== bench/atsl_slot_checker.sv =====
// ----------------------------------------------------------------------------
// atsl_slot_checker
// Watches the request and result channels of the texture slot table, keeps
// its own copy of the table, and checks every result word against the slot,
// miss and eviction that the table should report for the request behind it.
// ----------------------------------------------------------------------------
module atsl_slot_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  atsl_req_if         req_i,
  atsl_rsp_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned hits_o,
  output int unsigned fills_o,
  output int unsigned evicts_o
);
  import atsl_pkg::*;

  // shadow of the slot table
  logic [KEY_W-1:0] shadow_key_lo [ENTRIES];
  logic [KEY_W-1:0] shadow_key_hi [ENTRIES];
  stamp_t           shadow_stamp  [ENTRIES];
  int unsigned      shadow_fill = 0;

  // slot results still owed by the block, oldest first
  rsp_t        owed_slots [$];
  int unsigned mismatch_cnt = 0;
  int unsigned hit_cnt      = 0;
  int unsigned fill_cnt     = 0;
  int unsigned evict_cnt    = 0;

  // look up one key, update the shadow table and return the expected word
  function automatic rsp_t bind_texture(input logic [KEY_W-1:0] klo,
                                        input logic [KEY_W-1:0] khi,
                                        input logic [NOW_W-1:0] now);
    rsp_t        res;
    stamp_t      now_s;
    stamp_t      age;
    stamp_t      oldest;
    int unsigned pick;
    bit          found;
    res   = '0;
    now_s = stamp_t'(now);
    pick  = 0;
    found = 1'b0;
    // first filled entry with an exact 128-bit match wins
    for (int unsigned i = 0; i < shadow_fill; i++) begin
      if (!found && shadow_key_lo[i] == klo && shadow_key_hi[i] == khi) begin
        pick  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      res.miss = 1'b1;
      if (shadow_fill < ENTRIES) begin
        pick = shadow_fill;
        shadow_fill++;
      end else begin
        // greatest wrapped age, lowest index on a tie
        oldest = now_s - shadow_stamp[0];
        for (int unsigned i = 1; i < ENTRIES; i++) begin
          age = now_s - shadow_stamp[i];
          if (age > oldest) begin
            oldest = age;
            pick   = i;
          end
        end
        res.replaced = 1'b1;
      end
      shadow_key_lo[pick] = klo;
      shadow_key_hi[pick] = khi;
    end
    shadow_stamp[pick] = now_s;
    res.slot = SLOT_W'(pick);
    return res;
  endfunction

  // compare each accepted result word, then predict each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      owed_slots.delete();
      shadow_fill = 0;
      errors_o  <= 0;
      pending_o <= 0;
      hits_o    <= 0;
      fills_o   <= 0;
      evicts_o  <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.slot     = rsp_i.slot;
        got.miss     = rsp_i.miss;
        got.replaced = rsp_i.replaced;
        if (owed_slots.size() == 0) begin
          $error("result word with no request waiting: slot %0d miss %0b replaced %0b",
                 got.slot, got.miss, got.replaced);
          mismatch_cnt++;
        end else begin
          want = owed_slots.pop_front();
          if (got.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
            mismatch_cnt++;
          end
          if (got.miss !== want.miss) begin
            $error("miss mismatch: expected %0b, actual %0b", want.miss, got.miss);
            mismatch_cnt++;
          end
          if (got.replaced !== want.replaced) begin
            $error("replaced mismatch: expected %0b, actual %0b",
                   want.replaced, got.replaced);
            mismatch_cnt++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = bind_texture(req_i.key_low, req_i.key_high, req_i.now_time);
        owed_slots.push_back(want);
        if (!want.miss) hit_cnt++;
        else if (want.replaced) evict_cnt++;
        else fill_cnt++;
      end
      errors_o  <= mismatch_cnt;
      pending_o <= owed_slots.size();
      hits_o    <= hit_cnt;
      fills_o   <= fill_cnt;
      evicts_o  <= evict_cnt;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives lookup requests into the texture slot table and stalls its result
// channel; a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
// A directed opening fills the table, hits, evicts on age, breaks an age tie
// and wraps the time. Random phases then draw keys from working sets of
// varying size so that hits, fills and evictions all occur, with bursty
// requests, patterned result stalls, one long result hold-off and drains
// between phases.
module testbench;
  import atsl_pkg::*;

  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_WORDS  = 205;
  localparam int unsigned POOL_MAX     = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 16;
  localparam int unsigned IDLE_LIMIT   = 5000;

  logic clk;
  logic rst_n;

  atsl_req_if req_if ();
  atsl_rsp_if rsp_if ();

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned hit_cnt;
  int unsigned fill_cnt;
  int unsigned evict_cnt;

  bit               hold_rsp = 1'b0;
  bit               steady   = 1'b1;
  int unsigned      burst_left = 0;
  int unsigned      sent_cnt   = 0;
  logic [NOW_W-1:0] clock_now;
  logic [KEY_W-1:0] pool_lo [POOL_MAX];
  logic [KEY_W-1:0] pool_hi [POOL_MAX];
  int unsigned      pool_n;

  assoc_texture_slot_lru uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  atsl_slot_checker slot_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (err_cnt),
    .pending_o (pending),
    .hits_o    (hit_cnt),
    .fills_o   (fill_cnt),
    .evicts_o  (evict_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one request word, with a random gap between bursts
  task automatic offer_word(input logic [KEY_W-1:0] klo, input logic [KEY_W-1:0] khi,
                            input logic [NOW_W-1:0] now);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    req_if.valid    <= 1'b1;
    req_if.key_low  <= klo;
    req_if.key_high <= khi;
    req_if.now_time <= now;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent_cnt++;
  endtask

  // drop valid and hold until every owed result word has arrived
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly working-set keys, some fresh, some half-matching, some extremes
  task automatic pick_key(output logic [KEY_W-1:0] klo, output logic [KEY_W-1:0] khi);
    int unsigned roll;
    int unsigned idx;
    roll = $urandom_range(0, 99);
    idx  = $urandom_range(0, pool_n - 1);
    klo  = pool_lo[idx];
    khi  = pool_hi[idx];
    if (roll >= 75 && roll < 85) begin
      klo = {$urandom, $urandom};
      khi = {$urandom, $urandom};
    end else if (roll >= 85 && roll < 93) begin
      if ($urandom_range(0, 1)) klo = {$urandom, $urandom};
      else khi = {$urandom, $urandom};
    end else if (roll >= 93) begin
      klo = $urandom_range(0, 1) ? '1 : '0;
      khi = $urandom_range(0, 1) ? '1 : '0;
    end
  endtask

  // advance time in small steps, with occasional jumps and backward steps
  task automatic step_time();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) clock_now = clock_now + $urandom_range(0, 3);
    else if (roll < 95) clock_now = $urandom;
    else clock_now = clock_now - $urandom_range(1, 1000);
  endtask

  // result-side stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    rsp_if.ready = 1'b0;
    mode      = 0;
    span      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        hold_rsp <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(40, 300);
      end
      span--;
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            rsp_if.ready <= 1'b1;
          end
          1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp_if.ready <= ($urandom_range(0, 4) == 0);
          end
          default: begin
            rsp_if.ready <= span[2];
          end
        endcase
      end
    end
  end

  // end the run when no word moves on either channel for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d results owed", idle, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [KEY_W-1:0] klo;
    logic [KEY_W-1:0] khi;
    int unsigned      pool_sizes [PHASES];
    pool_sizes = '{10, 18, 30, 64, 16};
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.key_low  = '0;
    req_if.key_high = '0;
    req_if.now_time = '0;
    clock_now       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill from empty with both extreme keys, then hit the first entry
    offer_word('0, '0, '0);
    offer_word('1, '1, '0);
    offer_word('0, '0, 32'd5);
    // fill the rest of the table at one time
    for (int unsigned i = 2; i < ENTRIES; i++) begin
      offer_word(64'h1000 + i, 64'hA5A5_5A5A_0F0F_F0F0, 32'd100);
    end
    // evict on age: oldest first, then the next oldest, then a full tie
    offer_word(64'h2000, 64'hA5A5_5A5A_0F0F_F0F0, 32'd100);
    offer_word(64'h2001, 64'hA5A5_5A5A_0F0F_F0F0, 32'd100);
    offer_word(64'h2002, 64'hA5A5_5A5A_0F0F_F0F0, 32'd100);
    // hit, then a miss whose time lies behind that entry's stamp
    offer_word(64'h1005, 64'hA5A5_5A5A_0F0F_F0F0, 32'd200);
    offer_word(64'h2003, 64'hA5A5_5A5A_0F0F_F0F0, 32'd50);
    // keys matching in one half only, at the top of the time range
    offer_word(64'h1007, 64'h5A5A_A5A5_F0F0_0F0F, 32'hFFFF_FFFF);
    offer_word(64'h0000_0000_0000_9999, 64'hA5A5_5A5A_0F0F_F0F0, 32'hFFFF_FFFF);
    drain_results();

    // random phases over working sets of different sizes
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      pool_n = pool_sizes[ph];
      for (int unsigned i = 0; i < pool_n; i++) begin
        pool_lo[i] = {$urandom, $urandom};
        pool_hi[i] = {$urandom, $urandom};
      end
      steady = (ph == 3);
      if (ph == 1) hold_rsp <= 1'b1;
      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        pick_key(klo, khi);
        step_time();
        offer_word(klo, khi, clock_now);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d lookups: %0d hits, %0d fills, %0d evictions",
             sent_cnt, hit_cnt, fill_cnt, evict_cnt);
    $display("Working sets of 10 to 64 keys, wrapped times, bursty input, stalled output");
    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/atsl_pkg.sv
rtl/atsl_if.sv
rtl/atsl_entry_mem.sv
rtl/atsl_out_reg.sv
rtl/atsl_ctrl.sv
rtl/assoc_texture_slot_lru.sv
bench/atsl_slot_checker.sv
bench/testbench.sv
